/* rtl/vtx4_pkg.sv */
// Shared definitions for the 4x4 vertex transform block.
// Holds the command codes, the configuration register count and the index, data and port widths; no dependencies.
package vtx4_pkg;

    typedef enum logic {
        CMD_POINT  = 1'b0,
        CMD_NORMAL = 1'b1
    } t_cmd;

    localparam int unsigned NUM_CFG_REGS = 8;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 64;
    localparam int unsigned PORT_W       = 32;

endpackage

/* rtl/vertex_transform_4x4.sv */
// Vertex transform: 3-vector times 4x4 fixed-point matrix, with perspective divide.
// Depends on vtx4_pkg for command codes and configuration constants.
// Throughput: one request per cycle while the output is not stalled; the divide is a restoring divider with one
// quotient bit per pipeline stage, three lanes wide, so it never iterates.
// The whole pipeline advances together whenever the output register is free or taken.
// Reset clears all valid bits and loads the identity matrix into the registers.
module vertex_transform_4x4 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic signed [vtx4_pkg::PORT_W-1:0] i_vec_x,
    input  logic signed [vtx4_pkg::PORT_W-1:0] i_vec_y,
    input  logic signed [vtx4_pkg::PORT_W-1:0] i_vec_z,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [vtx4_pkg::PORT_W-1:0] o_res_x,
    output logic signed [vtx4_pkg::PORT_W-1:0] o_res_y,
    output logic signed [vtx4_pkg::PORT_W-1:0] o_res_z,
    output logic                              o_saturated,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vtx4_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vtx4_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import vtx4_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;
    localparam int SW  = 2 * DW + 3;
    localparam int QW  = DW + FRAC_BITS;
    localparam int HW  = 32;

    localparam logic signed [DW-1:0] ONE    = DW'(1) << FRAC_BITS;
    localparam logic signed [DW-1:0] MAXV   = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MINV   = {1'b1, {(DW-1){1'b0}}};

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_cfg [NUM_CFG_REGS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                r_cfg[i] <= '0;
            end
            r_cfg[0] <= CFG_DATA_W'(ONE);
            r_cfg[2] <= CFG_DATA_W'(ONE) << HW;
            r_cfg[5] <= CFG_DATA_W'(ONE);
            r_cfg[7] <= CFG_DATA_W'(ONE) << HW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // Matrix elements m[row][col].
    logic signed [DW-1:0] m [4][4];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (c % 2 == 0) begin
                    m[r][c] = signed'(r_cfg[2*r + c/2][DW-1:0]);
                end else begin
                    m[r][c] = signed'(r_cfg[2*r + c/2][HW+DW-1:HW]);
                end
            end
        end
    end

    logic adv;
    logic r_out_valid;
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // Stage 1: input capture.
    logic                 r1_vld, r1_point;
    logic signed [DW-1:0] r1_v [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_point <= (t_cmd'(i_cmd) == CMD_POINT);
            r1_v[0]  <= signed'(i_vec_x[DW-1:0]);
            r1_v[1]  <= signed'(i_vec_y[DW-1:0]);
            r1_v[2]  <= signed'(i_vec_z[DW-1:0]);
        end
    end

    // Stage 2: twelve products.
    logic                 r2_vld, r2_point;
    logic signed [PW-1:0] r2_p [4][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (adv) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_point <= r1_point;
            for (int c = 0; c < 4; c++) begin
                for (int i = 0; i < 3; i++) begin
                    r2_p[c][i] <= PW'(r1_v[i]) * PW'(m[i][c]);
                end
            end
        end
    end

    // Stage 3: exact sums, floor shift, translation.
    logic                 r3_vld, r3_point;
    logic signed [SW-1:0] r3_d [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] n_sum;
        if (adv) begin
            r3_point <= r2_point;
            for (int c = 0; c < 4; c++) begin
                n_sum = SW'(r2_p[c][0]) + SW'(r2_p[c][1]) + SW'(r2_p[c][2]);
                n_sum = n_sum >>> FRAC_BITS;
                if (r2_point) begin
                    n_sum = n_sum + SW'(m[3][c]);
                end
                r3_d[c] <= n_sum;
            end
        end
    end

    // Stage 4: clipping, weight tests, magnitudes for the divider.
    logic signed [DW-1:0] cl [4];
    logic                 cl_sat [4];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (r3_d[c] > SW'(MAXV)) begin
                cl[c] = MAXV;
                cl_sat[c] = 1'b1;
            end else if (r3_d[c] < SW'(MINV)) begin
                cl[c] = MINV;
                cl_sat[c] = 1'b1;
            end else begin
                cl[c] = r3_d[c][DW-1:0];
                cl_sat[c] = 1'b0;
            end
        end
    end

    // Divider pipeline: index 0 is the stage 4 register, index QW the last quotient bit.
    logic                 r_vld  [QW+1];
    logic                 r_div  [QW+1];
    logic                 r_sat  [QW+1];
    logic [DW-1:0]        r_den  [QW+1];
    logic signed [DW-1:0] r_res  [QW+1][3];
    logic                 r_neg  [QW+1][3];
    logic [DW:0]          r_rem  [QW+1][3];
    logic [QW-1:0]        r_num  [QW+1][3];
    logic [QW-1:0]        r_q    [QW+1][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [DW-1:0] n_mag;
        if (adv) begin
            r_div[0] <= r3_point && (cl[3] != ONE) && (cl[3] != '0);
            r_sat[0] <= cl_sat[0] || cl_sat[1] || cl_sat[2] || (r3_point && cl_sat[3]);
            r_den[0] <= cl[3][DW-1] ? DW'(-cl[3]) : DW'(cl[3]);
            for (int j = 0; j < 3; j++) begin
                n_mag       = cl[j][DW-1] ? DW'(-cl[j]) : DW'(cl[j]);
                r_res[0][j] <= cl[j];
                r_neg[0][j] <= cl[j][DW-1] ^ cl[3][DW-1];
                r_rem[0][j] <= '0;
                r_num[0][j] <= QW'(n_mag) << FRAC_BITS;
                r_q[0][j]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [DW:0] n_rem;
            if (adv) begin
                r_div[k+1] <= r_div[k];
                r_sat[k+1] <= r_sat[k];
                r_den[k+1] <= r_den[k];
                for (int j = 0; j < 3; j++) begin
                    n_rem = {r_rem[k][j][DW-1:0], r_num[k][j][QW-1]};
                    r_res[k+1][j] <= r_res[k][j];
                    r_neg[k+1][j] <= r_neg[k][j];
                    r_num[k+1][j] <= r_num[k][j] << 1;
                    if (n_rem >= {1'b0, r_den[k]}) begin
                        r_rem[k+1][j] <= n_rem - {1'b0, r_den[k]};
                        r_q[k+1][j]   <= {r_q[k][j][QW-2:0], 1'b1};
                    end else begin
                        r_rem[k+1][j] <= n_rem;
                        r_q[k+1][j]   <= {r_q[k][j][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Output stage: sign, clip of quotient, bypass selection.
    logic signed [DW-1:0] r_out [3];
    logic                 r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [QW:0] n_sq;
        logic               n_sat;
        if (adv) begin
            n_sat = r_sat[QW];
            for (int j = 0; j < 3; j++) begin
                n_sq = r_neg[QW][j] ? -signed'({1'b0, r_q[QW][j]}) : signed'({1'b0, r_q[QW][j]});
                if (!r_div[QW]) begin
                    r_out[j] <= r_res[QW][j];
                end else if (n_sq > (QW+1)'(MAXV)) begin
                    r_out[j] <= MAXV;
                    n_sat = 1'b1;
                end else if (n_sq < (QW+1)'(MINV)) begin
                    r_out[j] <= MINV;
                    n_sat = 1'b1;
                end else begin
                    r_out[j] <= n_sq[DW-1:0];
                end
            end
            r_out_sat <= n_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res_x     = PORT_W'(r_out[0]);
    assign o_res_y     = PORT_W'(r_out[1]);
    assign o_res_z     = PORT_W'(r_out[2]);
    assign o_saturated = r_out_sat;

    // A normal request is never marked for divide.
    a_normal_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r3_vld && !r3_point) |=> !r_div[0])
        else $error("normal request marked for divide");

    // The pipeline only accepts while the output register can move.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready out of step with output stall");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_res_x)
            && $stable(o_saturated)))
        else $error("stalled result changed");

    // No result appears in the cycle after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

/* test/vertex_transform_4x4_test.sv */
// Self-checking testbench for vertex_transform_4x4: random and directed vectors,
// a software model of the matrix transform, and randomized handshake stalls.
// Depends on vtx4_pkg and the vertex_transform_4x4 RTL.
module vertex_transform_4x4_test;
    import vtx4_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;
    localparam int LATENCY = DW + FB + 5;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
    } t_vertex_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = 1'b0;
    logic signed [PORT_W-1:0] i_vec_x = '0;
    logic signed [PORT_W-1:0] i_vec_y = '0;
    logic signed [PORT_W-1:0] i_vec_z = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [PORT_W-1:0] o_res_x;
    logic signed [PORT_W-1:0] o_res_y;
    logic signed [PORT_W-1:0] o_res_z;
    logic        o_saturated;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [63:0] matrix_regs [NUM_CFG_REGS];
    t_vertex_out expected_vertices [$];
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          drain_stall = 1'b0;

    vertex_transform_4x4 u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic longint matrix_elem(input int r, input int c);
        logic [63:0] word;
        word = matrix_regs[2 * r + c / 2];
        return longint'($signed(c % 2 ? word[63:32] : word[31:0]));
    endfunction

    // Exact sum of products floored to FB fraction bits; 128-bit math avoids overflow.
    function automatic longint dot_column(input longint v[3], input int c,
                                          input bit add_row3);
        logic signed [127:0] acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += 128'(v[i]) * 128'(matrix_elem(i, c));
        acc = acc >>> FB;
        if (add_row3)
            acc += 128'(matrix_elem(3, c));
        if (acc > 128'sd2147483647) return 64'sd2147483648;
        if (acc < -128'sd2147483648) return -64'sd2147483649;
        return longint'(acc);
    endfunction

    function automatic longint clip32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_vertex_out transform_vertex(input t_cmd cmd,
            input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        longint v[3];
        longint r[3];
        longint w;
        bit sat;
        t_vertex_out res;
        sat = 1'b0;
        v[0] = longint'($signed(x));
        v[1] = longint'($signed(y));
        v[2] = longint'($signed(z));
        for (int j = 0; j < 3; j++)
            r[j] = clip32(dot_column(v, j, cmd == CMD_POINT), sat);
        if (cmd == CMD_POINT) begin
            w = clip32(dot_column(v, 3, 1'b1), sat);
            if (w != ONE && w != 0)
                for (int j = 0; j < 3; j++)
                    r[j] = clip32((r[j] <<< FB) / w, sat);
        end
        res.x = r[0][31:0];
        res.y = r[1][31:0];
        res.z = r[2][31:0];
        res.sat = sat;
        return res;
    endfunction

    function automatic void ref_reset_matrix();
        for (int i = 0; i < NUM_CFG_REGS; i++) matrix_regs[i] = '0;
        matrix_regs[0] = 64'(ONE);
        matrix_regs[2] = 64'(ONE) << 32;
        matrix_regs[5] = 64'(ONE);
        matrix_regs[7] = 64'(ONE) << 32;
    endfunction

    // Result checker with a random, possibly zero, stall before each accepted result.
    initial begin
        int stall;
        t_vertex_out want;
        @(posedge i_clk);
        forever begin
            stall = drain_stall ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            if (expected_vertices.size() == 0) begin
                report_mismatch("unexpected result", o_res_x, 32'h0);
            end else begin
                want = expected_vertices.pop_front();
                if (o_res_x !== want.x) report_mismatch("res_x", o_res_x, want.x);
                if (o_res_y !== want.y) report_mismatch("res_y", o_res_y, want.y);
                if (o_res_z !== want.z) report_mismatch("res_z", o_res_z, want.z);
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", 32'(o_saturated), 32'(want.sat));
            end
        end
    end

    task automatic send_vertex(input t_cmd cmd, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        do @(posedge i_clk); while (!o_in_ready);
        expected_vertices.push_back(transform_vertex(cmd, x, y, z));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // The write channel drops valid and goes idle after each request.
    task automatic write_matrix_reg(input int idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        matrix_regs[idx] = data;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            3: return 32'h8000_0000 ^ 32'($urandom_range(0, 3));
            4: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            default: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
        endcase
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
            2: return ONE[31:0];
            3: return '0;
            default: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
        endcase
    endfunction

    task automatic load_identity();
        for (int i = 0; i < NUM_CFG_REGS; i++) write_matrix_reg(i, 64'd0);
        write_matrix_reg(0, 64'(ONE));
        write_matrix_reg(2, 64'(ONE) << 32);
        write_matrix_reg(5, 64'(ONE));
        write_matrix_reg(7, 64'(ONE) << 32);
    endtask

    task automatic test_directed_identity();
        logic [31:0] edges [6];
        edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
                  32'hFFFF_0000};
        for (int i = 0; i < 6; i++) begin
            send_vertex(CMD_POINT, edges[i], edges[(i + 1) % 6], edges[(i + 2) % 6]);
            send_vertex(CMD_NORMAL, edges[i], edges[(i + 3) % 6], edges[(i + 4) % 6]);
        end
        wait_idle();
    endtask

    // Weight column set so w follows x: zero, tiny, fractional, or at the signed limits.
    task automatic test_directed_weight();
        write_matrix_reg(1, {32'h0001_0000, 32'h0002_0000});
        write_matrix_reg(3, {32'h0, 32'h0001_0000});
        write_matrix_reg(5, {32'h0, 32'h0001_0000});
        write_matrix_reg(6, {32'h0003_0000, 32'hFFFF_0000});
        write_matrix_reg(7, {32'h0, 32'h0000_8000});
        send_vertex(CMD_POINT, 32'h0, 32'h1, 32'h5);
        send_vertex(CMD_POINT, 32'h0000_8000, 32'h0, 32'h0);
        send_vertex(CMD_POINT, 32'hFFFF_8000, 32'h7, 32'h0);
        send_vertex(CMD_POINT, 32'h0000_0001, 32'h0, 32'h0);
        send_vertex(CMD_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vertex(CMD_POINT, 32'h8000_0000, 32'h1234_5678, 32'h0);
        send_vertex(CMD_NORMAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_idle();
    endtask

    task automatic test_extreme_matrix();
        for (int i = 0; i < NUM_CFG_REGS; i++)
            write_matrix_reg(i, i % 2 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h8000_0000_7FFF_FFFF);
        for (int n = 0; n < 6; n++)
            send_vertex(t_cmd'(n % 2), rand_coord(), rand_coord(), rand_coord());
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 12; phase++) begin
            if (phase == 0)
                load_identity();
            else
                for (int i = 0; i < NUM_CFG_REGS; i++)
                    write_matrix_reg(i, {rand_elem(), rand_elem()});
            drain_stall = (phase % 4 == 3);
            for (int n = 0; n < 150; n++)
                send_vertex(t_cmd'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                            rand_coord());
            wait_idle();
        end
        drain_stall = 1'b0;
    endtask

    initial begin
        ref_reset_matrix();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_identity();
        test_directed_weight();
        test_extreme_matrix();
        test_random_phases();
        wait_idle();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
